// ----- rtl/mips_subset_execute_unit_core_defines.svh -----
// ----------------------------------------------------------------------------
// MIPS subset execute unit: assertion macros
// Concurrent check macros used by the execute core. They refer to the
// clock and reset signals of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef MIPS_SUBSET_EXECUTE_UNIT_CORE_DEFINES_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset
`define MSE_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("mse assertion failed");

// Check a property on every clock edge, reset included
`define MSE_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("mse assertion failed");

`else

`define MSE_ASSERT(label, prop)
`define MSE_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ----- rtl/mse_pkg.sv -----
// ----------------------------------------------------------------------------
// MIPS subset execute unit package
// Instruction field positions, opcode and funct codes, operation kinds and
// the structs passed between the decode/ALU, register file and core.
// ----------------------------------------------------------------------------
`default_nettype none

package mse_pkg;

   // Instruction word layout
   localparam int INSTR_W  = 32;
   localparam int DATA_W   = 32;
   localparam int REG_AW   = 5;
   localparam int REG_NUM  = 32;
   localparam int OPC_LSB  = 26;
   localparam int OPC_W    = 6;
   localparam int RS_LSB   = 21;
   localparam int RT_LSB   = 16;
   localparam int RD_LSB   = 11;
   localparam int FUNCT_W  = 6;
   localparam int IMM_W    = 16;

   // Primary opcodes
   localparam logic [OPC_W-1:0] OPC_RTYPE = 6'd0;
   localparam logic [OPC_W-1:0] OPC_J     = 6'd2;
   localparam logic [OPC_W-1:0] OPC_JAL   = 6'd3;
   localparam logic [OPC_W-1:0] OPC_BEQ   = 6'd4;
   localparam logic [OPC_W-1:0] OPC_BNE   = 6'd5;
   localparam logic [OPC_W-1:0] OPC_ADDI  = 6'd8;
   localparam logic [OPC_W-1:0] OPC_LW    = 6'd35;
   localparam logic [OPC_W-1:0] OPC_SW    = 6'd43;

   // R-type funct codes
   localparam logic [FUNCT_W-1:0] FN_SLL  = 6'd0;
   localparam logic [FUNCT_W-1:0] FN_JR   = 6'd8;
   localparam logic [FUNCT_W-1:0] FN_MULT = 6'd24;
   localparam logic [FUNCT_W-1:0] FN_DIV  = 6'd26;
   localparam logic [FUNCT_W-1:0] FN_ADD  = 6'd32;
   localparam logic [FUNCT_W-1:0] FN_SUB  = 6'd34;
   localparam logic [FUNCT_W-1:0] FN_AND  = 6'd36;
   localparam logic [FUNCT_W-1:0] FN_OR   = 6'd37;
   localparam logic [FUNCT_W-1:0] FN_SLT  = 6'd42;

   // Reported operation kind
   typedef enum logic [3:0] {
      KIND_AND  = 4'd0,
      KIND_OR   = 4'd1,
      KIND_ADD  = 4'd2,
      KIND_MULT = 4'd3,
      KIND_DIV  = 4'd4,
      KIND_SLL  = 4'd5,
      KIND_SUB  = 4'd6,
      KIND_SLT  = 4'd7,
      KIND_JR   = 4'd8,
      KIND_J    = 4'd9,
      KIND_JAL  = 4'd10,
      KIND_BEQ  = 4'd11,
      KIND_BNE  = 4'd12,
      KIND_ADDI = 4'd13,
      KIND_LW   = 4'd14,
      KIND_SW   = 4'd15
   } kind_type;

   // One result item
   typedef struct packed {
      logic                     write_enable;
      logic [REG_AW-1:0]        dest_register;
      logic signed [DATA_W-1:0] write_value;
      logic                     alu_zero;
      logic                     bad_opcode;
      kind_type                 op_kind;
   } result_type;

   // Register file write port
   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] addr;
      logic [DATA_W-1:0] data;
   } wr_port_type;

endpackage

`default_nettype wire

// ----- rtl/mse_regfile.sv -----
// ----------------------------------------------------------------------------
// MIPS subset execute unit register file
// 32 x 32 memory with one write port and two registered read ports. Valid
// bits cleared at reset make unwritten entries (and register zero) read as
// zero; a write landing on the same edge as a read is forwarded.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_regfile (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rd_en,
   input  wire logic [mse_pkg::REG_AW-1:0]   rd_addr_a,
   input  wire logic [mse_pkg::REG_AW-1:0]   rd_addr_b,
   input  wire mse_pkg::wr_port_type         wr,
   output logic      [mse_pkg::DATA_W-1:0]   rd_data_a,
   output logic      [mse_pkg::DATA_W-1:0]   rd_data_b
);

   logic [mse_pkg::DATA_W-1:0]  mem [mse_pkg::REG_NUM];
   logic [mse_pkg::REG_NUM-1:0] valid_ff;
   logic [mse_pkg::DATA_W-1:0]  rd_a_ff;
   logic [mse_pkg::DATA_W-1:0]  rd_b_ff;
   logic [mse_pkg::DATA_W-1:0]  fwd_data_ff;
   logic                        vld_a_ff;
   logic                        vld_b_ff;
   logic                        fwd_a_ff;
   logic                        fwd_b_ff;
   logic                        fwd_a_in;
   logic                        fwd_b_in;

   // Detect a write to the address being read on the same edge
   assign fwd_a_in = wr.en && (wr.addr == rd_addr_a);
   assign fwd_b_in = wr.en && (wr.addr == rd_addr_b);

   // Memory write and registered reads
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_a_ff     <= mem[rd_addr_a];
         rd_b_ff     <= mem[rd_addr_b];
         fwd_data_ff <= wr.data;
      end
   end

   // Track written entries and capture read qualifiers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         fwd_a_ff <= 1'b0;
         fwd_b_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            vld_a_ff <= valid_ff[rd_addr_a];
            vld_b_ff <= valid_ff[rd_addr_b];
            fwd_a_ff <= fwd_a_in;
            fwd_b_ff <= fwd_b_in;
         end
      end
   end

   // Select forwarded, stored or reset value
   assign rd_data_a = fwd_a_ff ? fwd_data_ff : (vld_a_ff ? rd_a_ff : '0);
   assign rd_data_b = fwd_b_ff ? fwd_data_ff : (vld_b_ff ? rd_b_ff : '0);

endmodule

`default_nettype wire

// ----- rtl/mse_alu.sv -----
// ----------------------------------------------------------------------------
// MIPS subset execute unit decode and ALU
// Decodes one instruction word and computes the result item from the two
// register operands and the sign-extended immediate.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_alu (
   input  wire logic [mse_pkg::INSTR_W-1:0] instr,
   input  wire logic [mse_pkg::DATA_W-1:0]  op_a,
   input  wire logic [mse_pkg::DATA_W-1:0]  op_b,
   output mse_pkg::result_type              res
);

   logic [mse_pkg::OPC_W-1:0]   opc;
   logic [mse_pkg::FUNCT_W-1:0] funct;
   logic [mse_pkg::REG_AW-1:0]  rt;
   logic [mse_pkg::REG_AW-1:0]  rd;
   logic [mse_pkg::DATA_W-1:0]  simm;
   logic [mse_pkg::DATA_W-1:0]  sum_rr;
   logic [mse_pkg::DATA_W-1:0]  diff_rr;
   logic [mse_pkg::DATA_W-1:0]  sum_ri;
   logic                        eq_rr;
   logic                        eq_ri;
   logic                        lt_rr;
   logic                        alu_write;
   logic [mse_pkg::REG_AW-1:0]  dest;
   logic [mse_pkg::DATA_W-1:0]  val;
   logic                        zero;
   logic                        bad;
   mse_pkg::kind_type           kind;

   // Split the instruction word
   assign opc   = instr[mse_pkg::OPC_LSB +: mse_pkg::OPC_W];
   assign rt    = instr[mse_pkg::RT_LSB +: mse_pkg::REG_AW];
   assign rd    = instr[mse_pkg::RD_LSB +: mse_pkg::REG_AW];
   assign funct = instr[mse_pkg::FUNCT_W-1:0];
   assign simm  = {{(mse_pkg::DATA_W - mse_pkg::IMM_W){instr[mse_pkg::IMM_W-1]}},
                   instr[mse_pkg::IMM_W-1:0]};

   // Shared arithmetic
   assign sum_rr  = op_a + op_b;
   assign diff_rr = op_a - op_b;
   assign sum_ri  = op_a + simm;
   assign eq_rr   = (op_a == op_b);
   assign eq_ri   = (op_a == simm);
   assign lt_rr   = ($signed(op_a) < $signed(op_b));

   // Decode and select the result
   always_comb begin
      alu_write = 1'b0;
      dest      = '0;
      val       = '0;
      zero      = 1'b0;
      bad       = 1'b0;
      kind      = mse_pkg::KIND_AND;
      if (opc == mse_pkg::OPC_RTYPE) begin
         case (funct)
            mse_pkg::FN_ADD: begin
               kind = mse_pkg::KIND_ADD;
               val = sum_rr;
               alu_write = 1'b1;
            end
            mse_pkg::FN_SUB: begin
               kind = mse_pkg::KIND_SUB;
               val = diff_rr;
               alu_write = 1'b1;
            end
            mse_pkg::FN_AND: begin
               kind = mse_pkg::KIND_AND;
               val = op_a & op_b;
               alu_write = 1'b1;
            end
            mse_pkg::FN_OR: begin
               kind = mse_pkg::KIND_OR;
               val = op_a | op_b;
               alu_write = 1'b1;
            end
            mse_pkg::FN_SLT: begin
               kind = mse_pkg::KIND_SLT;
               val = {{(mse_pkg::DATA_W-1){1'b0}}, lt_rr};
               alu_write = 1'b1;
            end
            mse_pkg::FN_SLL:  kind = mse_pkg::KIND_SLL;
            mse_pkg::FN_JR:   kind = mse_pkg::KIND_JR;
            mse_pkg::FN_MULT: kind = mse_pkg::KIND_MULT;
            mse_pkg::FN_DIV:  kind = mse_pkg::KIND_DIV;
            default:          bad = 1'b1;
         endcase
         if (alu_write) begin
            dest = rd;
            zero = eq_rr;
         end
      end else begin
         case (opc)
            mse_pkg::OPC_J:   kind = mse_pkg::KIND_J;
            mse_pkg::OPC_JAL: kind = mse_pkg::KIND_JAL;
            mse_pkg::OPC_BEQ: begin
               kind = mse_pkg::KIND_BEQ;
               val = diff_rr;
               zero = eq_rr;
            end
            mse_pkg::OPC_BNE: begin
               kind = mse_pkg::KIND_BNE;
               val = diff_rr;
               zero = eq_rr;
            end
            mse_pkg::OPC_ADDI: begin
               kind = mse_pkg::KIND_ADDI;
               val = sum_ri;
               zero = eq_ri;
               dest = rt;
               alu_write = 1'b1;
            end
            mse_pkg::OPC_LW: begin
               kind = mse_pkg::KIND_LW;
               val = sum_ri;
               zero = eq_ri;
            end
            mse_pkg::OPC_SW: begin
               kind = mse_pkg::KIND_SW;
               val = sum_ri;
               zero = eq_ri;
            end
            default: bad = 1'b1;
         endcase
      end
   end

   // Pack the result; register zero is never written
   always_comb begin
      res.write_enable  = alu_write && (dest != '0);
      res.dest_register = dest;
      res.write_value   = $signed(val);
      res.alu_zero      = zero;
      res.bad_opcode    = bad;
      res.op_kind       = kind;
   end

endmodule

`default_nettype wire

// ----- rtl/mips_subset_execute_unit_core.sv -----
// ----------------------------------------------------------------------------
// MIPS subset execute unit core
// Executes one MIPS instruction word per item against a 32-entry register
// file: decode, operand read, ALU and write-back, one result per item.
//
// Channels: req_* carries one 32-bit instruction word per item; rsp_* returns
// one result item (write enable, destination, value, zero flag, bad-opcode
// flag and operation kind) for every accepted instruction, in order.
// Pipeline: an accepted item is held in the execute stage register, then in
// the result register that drives rsp_*. Throughput: one item per cycle while
// rsp_* is not stalled. The register file read is registered at acceptance;
// decode, ALU and write-back happen as the item moves into the result register,
// and a write on that same edge is forwarded to the next item's operands.
// Reset: both stages empty and the register file reads all zeros at once
// through per-entry valid bits; no clearing pass is needed.
// Stall: while rsp_ready is low with a result pending, the result register holds,
// the execute stage holds its item, and req_ready drops once that stage is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mips_subset_execute_unit_core_defines.svh"

module mips_subset_execute_unit_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic        [mse_pkg::INSTR_W-1:0] req_instruction,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_write_enable,
   output logic             [mse_pkg::REG_AW-1:0]  rsp_dest_register,
   output logic signed      [mse_pkg::DATA_W-1:0]  rsp_write_value,
   output logic                                    rsp_alu_zero,
   output logic                                    rsp_bad_opcode,
   output logic             [3:0]                  rsp_op_kind
);

   logic [mse_pkg::INSTR_W-1:0] instr_ff;
   logic                        ex_valid_ff;
   logic                        ex_valid_in;
   logic                        out_valid_ff;
   logic                        out_valid_in;
   mse_pkg::result_type         out_ff;
   mse_pkg::result_type         ex_res;
   mse_pkg::wr_port_type        wr;
   logic [mse_pkg::DATA_W-1:0]  op_a;
   logic [mse_pkg::DATA_W-1:0]  op_b;
   logic                        req_take;
   logic                        ex_adv;

   // Handshake: advance the execute stage when the result slot frees up
   assign ex_adv       = ex_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !ex_valid_ff || ex_adv;
   assign req_take     = req_valid && req_ready;
   assign ex_valid_in  = req_take || (ex_valid_ff && !ex_adv);
   assign out_valid_in = ex_adv || (out_valid_ff && !rsp_ready);

   // Write back as the item leaves the execute stage
   assign wr.en   = ex_adv && ex_res.write_enable;
   assign wr.addr = ex_res.dest_register;
   assign wr.data = $unsigned(ex_res.write_value);

   mse_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_take),
      .rd_addr_a (req_instruction[mse_pkg::RS_LSB +: mse_pkg::REG_AW]),
      .rd_addr_b (req_instruction[mse_pkg::RT_LSB +: mse_pkg::REG_AW]),
      .wr        (wr),
      .rd_data_a (op_a),
      .rd_data_b (op_b)
   );

   mse_alu u_alu (
      .instr (instr_ff),
      .op_a  (op_a),
      .op_b  (op_b),
      .res   (ex_res)
   );

   // Stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the instruction and the result payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         instr_ff <= req_instruction;
      end
      if (ex_adv) begin
         out_ff <= ex_res;
      end
   end

   // Drive the result channel
   assign rsp_valid         = out_valid_ff;
   assign rsp_write_enable  = out_ff.write_enable;
   assign rsp_dest_register = out_ff.dest_register;
   assign rsp_write_value   = out_ff.write_value;
   assign rsp_alu_zero      = out_ff.alu_zero;
   assign rsp_bad_opcode    = out_ff.bad_opcode;
   assign rsp_op_kind       = out_ff.op_kind;

   // Checks
   `MSE_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid && req_ready)
   `MSE_ASSERT(a_we_nonzero_dest, rsp_valid && rsp_write_enable |-> rsp_dest_register != '0)
   `MSE_ASSERT(a_bad_no_write, rsp_valid && rsp_bad_opcode |-> !rsp_write_enable && rsp_op_kind == '0)
   `MSE_ASSERT(a_write_only_on_adv, wr.en |-> ex_valid_ff && out_valid_in)

endmodule

`default_nettype wire
